### rtl/ghc_pkg.sv
package ghc_pkg;

  // Sector geometry
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned COUNT_W      = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(SECTOR_BYTES - 1);

  // Header layout and limits
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [31:0] GPT_REV     = 32'h00010000;
  localparam logic [31:0] HDR_MIN     = 32'd92;
  localparam logic [31:0] HDR_MAX     = 32'(SECTOR_BYTES);
  localparam logic [31:0] ENTRY_ALIGN = 32'd128;

  localparam int unsigned SIG_LEN     = 8;
  localparam int unsigned OFF_REV     = 8;
  localparam int unsigned OFF_HDR_LEN = 12;
  localparam int unsigned OFF_CRC     = 16;
  localparam int unsigned OFF_RSVD    = 20;
  localparam int unsigned OFF_OWN     = 24;
  localparam int unsigned OFF_ALT     = 32;
  localparam int unsigned OFF_FIRST   = 40;
  localparam int unsigned OFF_LAST    = 48;
  localparam int unsigned OFF_ARRAY   = 72;
  localparam int unsigned OFF_COUNT   = 80;
  localparam int unsigned OFF_ESIZE   = 84;

  localparam logic [7:0] SIG_BYTES [SIG_LEN] =
    '{8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54};

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXP_LBA    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARD_COUNT = 8'd1;

  // Result codes, in check order
  typedef enum logic [4:0] {
    ERR_NONE        = 5'd0,
    ERR_LENGTH      = 5'd1,
    ERR_SIGNATURE   = 5'd2,
    ERR_REVISION    = 5'd3,
    ERR_HDR_SIZE    = 5'd4,
    ERR_CRC         = 5'd5,
    ERR_RESERVED    = 5'd6,
    ERR_OWN_LBA     = 5'd7,
    ERR_LBA_RANGE   = 5'd8,
    ERR_ALT_LBA     = 5'd9,
    ERR_USABLE      = 5'd10,
    ERR_LAST_USABLE = 5'd11,
    ERR_ARRAY_LBA   = 5'd12,
    ERR_ENTRY_COUNT = 5'd13,
    ERR_ENTRY_SIZE  = 5'd14,
    ERR_ARRAY_FIT   = 5'd15,
    ERR_OVERLAP     = 5'd16
  } err_t;

  // Failure flags of the LBA and entry array checks
  typedef struct packed {
    logic own_lba;
    logic lba_range;
    logic alt_lba;
    logic usable;
    logic last_usable;
    logic array_lba;
    logic entry_count;
    logic entry_size;
    logic array_fit;
    logic overlap;
  } range_flags_t;

  // One byte through a reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

### rtl/ghc_if.sv
interface ghc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ghc_result_if;
  logic       valid;
  logic       ready;
  logic       header_valid;
  logic [4:0] error_code;

  modport source (output valid, output header_valid, output error_code, input ready);
  modport sink   (input valid, input header_valid, input error_code, output ready);
endinterface

interface ghc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ghc_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/gpt_header_checker.sv
// GPT header checker.
// The sector channel takes one byte per beat in address order; last_byte
// marks the final byte. The result channel gives one beat per sector:
// header_valid and error_code, the first check that failed (0 when all pass).
// The configuration channel writes expected_header_lba (index 0, reset 1) and
// card_sector_count (index 1, reset 0); it is always ready. The user must write
// it only between sectors; the block itself does not enforce this.
// Throughput: one byte per cycle, while no last byte waits on a stalled result.
// Each byte passes the CRC and the field capture registers in the cycle it is
// accepted; the result beat appears in the cycle after the last byte is
// accepted. The range checks run in a four stage pipeline behind the captured
// fields, which settle long before byte 511 of a full sector.
// Reset clears the byte count, the CRC, the signature flag and the result valid
// flag and restores the configuration defaults. While a result beat is stalled,
// data bytes keep flowing; only a further last byte waits until the result is taken.
module gpt_header_checker (
  input  logic           clk,
  input  logic           rst,
  ghc_byte_if.sink       sector,
  ghc_result_if.source   result,
  ghc_cfg_if.sink        cfg
);

  localparam int unsigned CW = ghc_pkg::COUNT_W;

  // configuration
  logic [31:0] exp_lba;
  logic [31:0] card_count;

  // per-sector control
  logic [CW-1:0] byte_count;
  logic [31:0]   running_crc;
  logic          signature_match;

  // captured fields
  logic [31:0] revision_word;
  logic [31:0] header_length;
  logic [31:0] stored_crc;
  logic [31:0] reserved_word;
  logic [63:0] own_lba;
  logic [63:0] alternate_lba;
  logic [63:0] first_usable;
  logic [63:0] last_usable;
  logic [63:0] array_lba;
  logic [31:0] entry_count;
  logic [31:0] entry_bytes;

  // result register
  logic          out_valid;
  logic          out_header_valid;
  ghc_pkg::err_t out_code;

  logic                  accept;
  logic                  accept_last;
  logic                  in_sector;
  logic                  crc_hit;
  logic [7:0]            crc_in;
  logic [31:0]           crc_next;
  ghc_pkg::err_t         code_next;
  ghc_pkg::range_flags_t flags;

  assign accept      = sector.valid && sector.ready;
  assign accept_last = accept && sector.last_byte;
  assign in_sector   = byte_count < CW'(ghc_pkg::SECTOR_BYTES);

  // A last byte waits only for room in the result register
  assign sector.ready = !out_valid || result.ready || !sector.last_byte;
  assign cfg.ready    = 1'b1;

  assign result.valid        = out_valid;
  assign result.header_valid = out_header_valid;
  assign result.error_code   = out_code;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_lba    <= 32'd1;
      card_count <= 32'd0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        ghc_pkg::CFG_EXP_LBA:    exp_lba    <= cfg.data;
        ghc_pkg::CFG_CARD_COUNT: card_count <= cfg.data;
        default: ;
      endcase
    end
  end

  // CRC over the header, stored CRC field hashed as zeros
  assign crc_hit = in_sector &&
                   ((byte_count < CW'(ghc_pkg::OFF_CRC)) ||
                    ({22'h0, byte_count} < header_length));
  assign crc_in  = ((byte_count >= CW'(ghc_pkg::OFF_CRC)) &&
                    (byte_count < CW'(ghc_pkg::OFF_CRC + 4))) ? 8'h00 : sector.data_byte;
  assign crc_next = crc_hit ? ghc_pkg::crc_byte(running_crc, crc_in) : running_crc;

  // Byte count, CRC and signature; clear after each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      running_crc     <= ghc_pkg::CRC_INIT;
      signature_match <= 1'b1;
    end else if (accept) begin
      if (sector.last_byte) begin
        byte_count      <= '0;
        running_crc     <= ghc_pkg::CRC_INIT;
        signature_match <= 1'b1;
      end else begin
        if (byte_count != ghc_pkg::COUNT_MAX) begin
          byte_count <= byte_count + CW'(1);
        end
        running_crc <= crc_next;
        if ((byte_count < CW'(ghc_pkg::SIG_LEN)) &&
            (sector.data_byte != ghc_pkg::SIG_BYTES[byte_count[2:0]])) begin
          signature_match <= 1'b0;
        end
      end
    end
  end

  // Capture little-endian fields at their offsets
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        if (byte_count == CW'(ghc_pkg::OFF_REV + k))     revision_word[8*k +: 8] <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_HDR_LEN + k)) header_length[8*k +: 8] <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_CRC + k))     stored_crc[8*k +: 8]    <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_RSVD + k))    reserved_word[8*k +: 8] <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_COUNT + k))   entry_count[8*k +: 8]   <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_ESIZE + k))   entry_bytes[8*k +: 8]   <= sector.data_byte;
      end
      for (int k = 0; k < 8; k++) begin
        if (byte_count == CW'(ghc_pkg::OFF_OWN + k))   own_lba[8*k +: 8]       <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_ALT + k))   alternate_lba[8*k +: 8] <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_FIRST + k)) first_usable[8*k +: 8]  <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_LAST + k))  last_usable[8*k +: 8]   <= sector.data_byte;
        if (byte_count == CW'(ghc_pkg::OFF_ARRAY + k)) array_lba[8*k +: 8]     <= sector.data_byte;
      end
    end
  end

  ghc_range_check u_range (
    .clk           (clk),
    .exp_lba       (exp_lba),
    .card_count    (card_count),
    .own_lba       (own_lba),
    .alternate_lba (alternate_lba),
    .first_usable  (first_usable),
    .last_usable   (last_usable),
    .array_lba     (array_lba),
    .entry_count   (entry_count),
    .entry_bytes   (entry_bytes),
    .flags         (flags)
  );

  // Pick the first failing check; the last byte of a full sector is index 511
  always_comb begin
    if (byte_count != ghc_pkg::LAST_INDEX)                         code_next = ghc_pkg::ERR_LENGTH;
    else if (!signature_match)                                     code_next = ghc_pkg::ERR_SIGNATURE;
    else if (revision_word != ghc_pkg::GPT_REV)                    code_next = ghc_pkg::ERR_REVISION;
    else if ((header_length < ghc_pkg::HDR_MIN) ||
             (header_length > ghc_pkg::HDR_MAX))                   code_next = ghc_pkg::ERR_HDR_SIZE;
    else if ((crc_next ^ ghc_pkg::CRC_INIT) != stored_crc)         code_next = ghc_pkg::ERR_CRC;
    else if (reserved_word != 32'd0)                               code_next = ghc_pkg::ERR_RESERVED;
    else if (flags.own_lba)                                        code_next = ghc_pkg::ERR_OWN_LBA;
    else if (flags.lba_range)                                      code_next = ghc_pkg::ERR_LBA_RANGE;
    else if (flags.alt_lba)                                        code_next = ghc_pkg::ERR_ALT_LBA;
    else if (flags.usable)                                         code_next = ghc_pkg::ERR_USABLE;
    else if (flags.last_usable)                                    code_next = ghc_pkg::ERR_LAST_USABLE;
    else if (flags.array_lba)                                      code_next = ghc_pkg::ERR_ARRAY_LBA;
    else if (flags.entry_count)                                    code_next = ghc_pkg::ERR_ENTRY_COUNT;
    else if (flags.entry_size)                                     code_next = ghc_pkg::ERR_ENTRY_SIZE;
    else if (flags.array_fit)                                      code_next = ghc_pkg::ERR_ARRAY_FIT;
    else if (flags.overlap)                                        code_next = ghc_pkg::ERR_OVERLAP;
    else                                                           code_next = ghc_pkg::ERR_NONE;
  end

  // Result register: load on the last byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_last) begin
      out_header_valid <= code_next == ghc_pkg::ERR_NONE;
      out_code         <= code_next;
    end
  end

endmodule

### rtl/ghc_range_check.sv
// LBA range and entry array checks. The header fields settle at byte 87 and
// stay put until the last byte, so this pipeline recomputes every cycle and
// its flags are steady once the fields have passed its last register stage.
module ghc_range_check (
  input  logic                  clk,
  input  logic [31:0]           exp_lba,
  input  logic [31:0]           card_count,
  input  logic [63:0]           own_lba,
  input  logic [63:0]           alternate_lba,
  input  logic [63:0]           first_usable,
  input  logic [63:0]           last_usable,
  input  logic [63:0]           array_lba,
  input  logic [31:0]           entry_count,
  input  logic [31:0]           entry_bytes,
  output ghc_pkg::range_flags_t flags
);

  localparam int unsigned SECTOR_SHIFT = $clog2(ghc_pkg::SECTOR_BYTES);

  logic [63:0] card64;
  logic [63:0] exp64;
  logic [63:0] cm1_32;
  logic [63:0] product_c;

  // stage 1
  logic [63:0] product;
  logic [63:0] card_m1;
  logic        f_own, f_range, f_alt, f_usable, f_last, f_array, f_count, f_size;
  // stage 2
  logic [63:0] sectors;
  // stage 3
  logic [63:0] array_end;
  logic [63:0] usable_end;
  logic [63:0] card_left;
  logic [63:0] card_m2;
  logic [63:0] card_m1_s;
  logic [63:0] two_s;
  // stage 4
  logic        f_fit, f_overlap;

  assign card64    = {32'h0, card_count};
  assign exp64     = {32'h0, exp_lba};
  assign cm1_32    = {32'h0, card_count - 32'd1};
  assign product_c = 64'(entry_count) * 64'(entry_bytes);

  // Simple field checks and the entry array size product
  always_ff @(posedge clk) begin
    product  <= product_c;
    card_m1  <= card64 - 64'd1;
    f_own    <= own_lba != exp64;
    f_range  <= (own_lba >= card64) || (alternate_lba >= card64) ||
                (own_lba == alternate_lba);
    f_alt    <= ((exp64 == 64'd1) && (alternate_lba != cm1_32)) ||
                ((exp64 == cm1_32) && (alternate_lba != 64'd1));
    f_usable <= (first_usable > last_usable) || (first_usable >= card64);
    f_last   <= last_usable >= card64;
    f_array  <= array_lba >= card64;
    f_count  <= entry_count == 32'd0;
    f_size   <= (entry_bytes < ghc_pkg::ENTRY_ALIGN) || (entry_bytes[6:0] != 7'd0);
  end

  // Round the array size up to whole sectors
  always_ff @(posedge clk) begin
    sectors <= (product + 64'(ghc_pkg::SECTOR_BYTES - 1)) >> SECTOR_SHIFT;
  end

  // Bounds of the array and of the usable space
  always_ff @(posedge clk) begin
    array_end  <= array_lba + sectors;
    usable_end <= last_usable + 64'd1;
    card_left  <= card64 - array_lba;
    card_m2    <= card64 - 64'd2;
    card_m1_s  <= card_m1 - sectors;
    two_s      <= sectors + 64'd2;
  end

  // Fit and overlap checks
  always_ff @(posedge clk) begin
    f_fit     <= (sectors == 64'd0) || f_array || (sectors > card_left);
    f_overlap <= (sectors > card_m2) ||
                 (first_usable < two_s) ||
                 (last_usable >= card_m1_s) ||
                 ((first_usable <= own_lba) && (own_lba < usable_end)) ||
                 ((first_usable <= alternate_lba) && (alternate_lba < usable_end)) ||
                 ((array_lba < usable_end) && (array_end > first_usable)) ||
                 ((array_lba <= own_lba) && (own_lba < array_end)) ||
                 ((array_lba <= alternate_lba) && (alternate_lba < array_end));
  end

  assign flags.own_lba     = f_own;
  assign flags.lba_range   = f_range;
  assign flags.alt_lba     = f_alt;
  assign flags.usable      = f_usable;
  assign flags.last_usable = f_last;
  assign flags.array_lba   = f_array;
  assign flags.entry_count = f_count;
  assign flags.entry_size  = f_size;
  assign flags.array_fit   = f_fit;
  assign flags.overlap     = f_overlap;

endmodule

### rtl/ghc_checker.sv
module ghc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       header_valid,
  input logic [4:0] error_code
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(header_valid) && $stable(error_code))
    else $error("result beat changed while stalled");

  // Valid flag agrees with the code
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (header_valid == (error_code == 5'(ghc_pkg::ERR_NONE))) &&
                  (error_code <= 5'(ghc_pkg::ERR_OVERLAP)))
    else $error("header_valid and error_code disagree");

  // Each accepted last byte yields a result beat in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result after last byte");

  // A result beat appears only after a last byte
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result without a last byte");

endmodule

bind gpt_header_checker ghc_checker u_ghc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sector.valid),
  .in_ready     (sector.ready),
  .in_last      (sector.last_byte),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .header_valid (result.header_valid),
  .error_code   (result.error_code)
);
